@@ design/mfr_pkg.sv @@
// shared types, codes and defaults for the monochrome frame store rectangle blitter
package mfr_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;

  localparam int MODE_W = 3;
  localparam int X_W    = 7;
  localparam int Y_W    = 6;

  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INVERT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OUTLINE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DOTTED  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

  // command queue depth, a power of two
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [X_W-1:0]    x1;
    logic [Y_W-1:0]    y1;
    logic [X_W-1:0]    x2;
    logic [Y_W-1:0]    y2;
    logic              reject;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_ROW,
    ST_BYTES,
    ST_READ,
    ST_WAIT,
    ST_DONE
  } back_state_t;

endpackage

@@ design/mono_framebuffer_rect_raster_top.sv @@
// top level of the monochrome frame store rectangle blitter
//
//  channel  dir  handshake             tdata                               tuser
//  in_      in   in_tvalid/in_tready   x_left, y_top, x_right, y_bottom    mode
//  out_     out  out_tvalid/out_tready page_byte                           status
//
// clear, invert, outline and dotted outline set up each row and then read-modify-write the
// bytes the row spans, one byte a cycle, through the store's one read and one write port
// a page byte read is made of eight single-byte reads; a rejected word goes straight to
// the result register
// after reset a clearing pass writes zero to every store byte, one a cycle, and in_tready
// stays low for that time
// a two-entry command queue keeps taking words while the blitter works or a result waits;
// the blitter starts the next command once the result register has been emptied
module mono_framebuffer_rect_raster_top #(
  parameter int PANEL_WIDTH  = mfr_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mfr_pkg::PANEL_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_left[6:0], y_top[12:7], x_right[19:13], y_bottom[25:20]
  input  logic [2:0]  in_tuser,   // mode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // page_byte[7:0]
  output logic [0:0]  out_tuser   // status[0]
);

  mfr_pkg::cmd_t    push_cmd;
  mfr_pkg::cmd_t    head;
  mfr_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;
  logic             clearing;

  // classify words as they arrive
  mfr_front #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .clearing (clearing),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples the input channel from the blitter
  mfr_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  // frame store and drawing sequencer
  mfr_back #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .clearing  (clearing),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

@@ design/mfr_front.sv @@
// front end: takes words from the input channel, checks corners and mode, queues commands
module mfr_front #(
  parameter int PANEL_WIDTH  = mfr_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mfr_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,
  input  logic [2:0]                in_tuser,
  input  logic                      clearing,
  input  mfr_pkg::q_stat_t          q_stat,
  output logic                      push,
  output mfr_pkg::cmd_t             push_cmd
);

  logic [mfr_pkg::MODE_W-1:0] mode;
  logic [mfr_pkg::X_W-1:0]    x1;
  logic [mfr_pkg::Y_W-1:0]    y1;
  logic [mfr_pkg::X_W-1:0]    x2;
  logic [mfr_pkg::Y_W-1:0]    y2;
  logic                       bad_read;
  logic                       bad_rect;

  assign mode = in_tuser[2:0];
  assign x1   = in_tdata[6:0];
  assign y1   = in_tdata[12:7];
  assign x2   = in_tdata[19:13];
  assign y2   = in_tdata[25:20];

  // off panel checks in widths that hold the panel size itself
  assign bad_read = (9'(x1) >= 9'(PANEL_WIDTH)) || (7'(y1) >= 7'(PANEL_HEIGHT));
  assign bad_rect = (x1 > x2) || (y1 > y2) ||
                    (9'(x2) >= 9'(PANEL_WIDTH)) || (7'(y2) >= 7'(PANEL_HEIGHT));

  assign in_tready = !clearing && !q_stat.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    push_cmd.mode = mode;
    push_cmd.x1   = x1;
    push_cmd.y1   = y1;
    push_cmd.x2   = x2;
    push_cmd.y2   = y2;
    if (mode == mfr_pkg::MODE_READ) begin
      push_cmd.reject = bad_read;
    end else if (mode > mfr_pkg::MODE_DOTTED) begin
      push_cmd.reject = 1'b1;
    end else begin
      push_cmd.reject = bad_rect;
    end
  end

endmodule

@@ design/mfr_cmd_queue.sv @@
// short command queue between the front end and the blitter
module mfr_cmd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mfr_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output mfr_pkg::cmd_t    head,
  output mfr_pkg::q_stat_t stat
);

  localparam int PTR_W = (mfr_pkg::QUEUE_DEPTH > 1) ? $clog2(mfr_pkg::QUEUE_DEPTH) : 1;

  mfr_pkg::cmd_t    slot_r [mfr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == (PTR_W+1)'(mfr_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ design/mfr_back.sv @@
// blitter: frame store memory, row and byte sequencer, read-modify-write pipe, result register
module mfr_back #(
  parameter int PANEL_WIDTH  = mfr_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mfr_pkg::PANEL_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mfr_pkg::cmd_t    head,
  input  mfr_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             clearing,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [0:0]       out_tuser
);

  localparam int PIXELS      = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int STORE_BYTES = (PIXELS + 7) / 8;
  localparam int LIN_W       = $clog2(PIXELS);
  localparam int ADDR_W      = LIN_W - 3;

  mfr_pkg::back_state_t state_r, state_nxt;

  logic [7:0]              mem [STORE_BYTES];
  logic [7:0]              rdata_r;

  mfr_pkg::cmd_t           cmd_r;
  logic [mfr_pkg::Y_W-1:0] row_y_r;
  logic [LIN_W-1:0]        row_base_r;
  logic [LIN_W-1:0]        pstart_r;
  logic [LIN_W-1:0]        pend_r;
  logic [ADDR_W-1:0]       byte_r;
  logic [ADDR_W-1:0]       clr_addr_r;

  logic                    s1_valid_r;
  logic [ADDR_W-1:0]       s1_addr_r;
  logic [7:0]              s1_mask_r;

  logic [2:0]              rd_k_r;
  logic [2:0]              rd_kd_r;
  logic                    rd_v_r;
  logic [2:0]              rd_bit_r;
  logic [7:0]              page_r;

  logic                    out_valid_r;
  logic [7:0]              out_page_r;
  logic                    out_status_r;

  logic [LIN_W-1:0]        p_start_c;
  logic [LIN_W-1:0]        p_end_c;
  logic                    first_byte;
  logic                    last_byte;
  logic                    clr_last;
  logic                    row_on_panel;
  logic [mfr_pkg::Y_W-1:0] start_row;
  logic [7:0]              mask_c;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [7:0]              mem_wdata;
  logic [ADDR_W-1:0]       rd_addr;
  logic [7:0]              rmw_data;

  assign p_start_c    = row_base_r + LIN_W'(cmd_r.x1);
  assign p_end_c      = row_base_r + LIN_W'(cmd_r.x2);
  assign first_byte   = (byte_r == pstart_r[LIN_W-1:3]);
  assign last_byte    = (byte_r == pend_r[LIN_W-1:3]);
  assign clr_last     = (clr_addr_r == ADDR_W'(STORE_BYTES - 1));
  assign row_on_panel = (7'(row_y_r) < 7'(PANEL_HEIGHT));
  // a read starts at the top row of the page
  assign start_row    = (head.mode == mfr_pkg::MODE_READ) ? {head.y1[5:3], 3'b000} : head.y1;

  // pixel mask of the current byte, pixel i of the byte sits at bit 7-i
  always_comb begin
    logic [2:0] lo;
    logic [2:0] hi;
    logic       edge_row;
    logic       in_span;
    logic       border;
    logic       even;
    lo       = first_byte ? pstart_r[2:0] : 3'd0;
    hi       = last_byte ? pend_r[2:0] : 3'd7;
    edge_row = (row_y_r == cmd_r.y1) || (row_y_r == cmd_r.y2);
    mask_c   = '0;
    for (int i = 0; i < 8; i++) begin
      in_span = (3'(i) >= lo) && (3'(i) <= hi);
      border  = edge_row || (first_byte && (3'(i) == lo)) || (last_byte && (3'(i) == hi));
      even    = !(1'(i) ^ pstart_r[0] ^ row_y_r[0] ^ cmd_r.y1[0]);
      unique case (cmd_r.mode)
        mfr_pkg::MODE_OUTLINE: mask_c[7-i] = in_span && border;
        mfr_pkg::MODE_DOTTED:  mask_c[7-i] = in_span && border && even;
        default:               mask_c[7-i] = in_span;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_r.mode)
      mfr_pkg::MODE_CLEAR:  rmw_data = rdata_r & ~s1_mask_r;
      mfr_pkg::MODE_INVERT: rmw_data = rdata_r ^ s1_mask_r;
      default:              rmw_data = rdata_r | s1_mask_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mfr_pkg::ST_CLR: begin
        if (clr_last) begin
          state_nxt = mfr_pkg::ST_IDLE;
        end
      end
      mfr_pkg::ST_IDLE: begin
        if (pop && !head.reject) begin
          state_nxt = (head.mode == mfr_pkg::MODE_READ) ? mfr_pkg::ST_READ : mfr_pkg::ST_ROW;
        end
      end
      mfr_pkg::ST_ROW: state_nxt = mfr_pkg::ST_BYTES;
      mfr_pkg::ST_BYTES: begin
        if (last_byte) begin
          state_nxt = (row_y_r == cmd_r.y2) ? mfr_pkg::ST_WAIT : mfr_pkg::ST_ROW;
        end
      end
      mfr_pkg::ST_READ: begin
        if (rd_k_r == 3'd7) begin
          state_nxt = mfr_pkg::ST_WAIT;
        end
      end
      mfr_pkg::ST_WAIT: state_nxt = mfr_pkg::ST_DONE;
      mfr_pkg::ST_DONE: state_nxt = mfr_pkg::ST_IDLE;
      default:          state_nxt = mfr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    clearing  = 1'b0;
    rd_addr   = byte_r;
    mem_we    = s1_valid_r;
    mem_waddr = s1_addr_r;
    mem_wdata = rmw_data;
    unique case (state_r)
      mfr_pkg::ST_CLR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      mfr_pkg::ST_IDLE: pop = !q_stat.empty && !out_valid_r;
      mfr_pkg::ST_READ: rd_addr = p_start_c[LIN_W-1:3];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfr_pkg::ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= (state_r == mfr_pkg::ST_BYTES);
      rd_v_r     <= (state_r == mfr_pkg::ST_READ) && row_on_panel;
      if (state_r == mfr_pkg::ST_CLR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if ((pop && head.reject) || (state_r == mfr_pkg::ST_DONE)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    s1_addr_r <= byte_r;
    s1_mask_r <= mask_c;
    rd_kd_r   <= rd_k_r;
    rd_bit_r  <= ~p_start_c[2:0];
    if (rd_v_r) begin
      page_r[rd_kd_r] <= rdata_r[rd_bit_r];
    end
    unique case (state_r)
      mfr_pkg::ST_IDLE: begin
        if (pop) begin
          cmd_r        <= head;
          row_y_r      <= start_row;
          row_base_r   <= LIN_W'(start_row * PANEL_WIDTH);
          rd_k_r       <= '0;
          page_r       <= '0;
          out_page_r   <= '0;
          out_status_r <= 1'b1;
        end
      end
      mfr_pkg::ST_ROW: begin
        pstart_r <= p_start_c;
        pend_r   <= p_end_c;
        byte_r   <= p_start_c[LIN_W-1:3];
      end
      mfr_pkg::ST_BYTES: begin
        if (last_byte) begin
          row_y_r    <= row_y_r + 1'b1;
          row_base_r <= row_base_r + LIN_W'(PANEL_WIDTH);
        end else begin
          byte_r <= byte_r + 1'b1;
        end
      end
      mfr_pkg::ST_READ: begin
        rd_k_r     <= rd_k_r + 1'b1;
        row_y_r    <= row_y_r + 1'b1;
        row_base_r <= row_base_r + LIN_W'(PANEL_WIDTH);
      end
      mfr_pkg::ST_DONE: begin
        out_page_r   <= (cmd_r.mode == mfr_pkg::MODE_READ) ? page_r : '0;
        out_status_r <= 1'b0;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_page_r;
  assign out_tuser  = out_status_r;

endmodule

@@ design/mfr_checker.sv @@
// port-level checks on the blitter top level, bound to it
module mfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [0:0]  out_tuser
);

  logic [2:0] pend_r;

  // words taken in and not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_tvalid && in_tready) - 3'(out_tvalid && out_tready);
    end
  end

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a rejected command never carries a page byte
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 8'd0)
    else $error("rejected result with nonzero page byte");

  // the store clearing pass holds off input after reset
  a_clear_hold: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during clearing pass");

  // no result without an outstanding command
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 3'd0)
    else $error("result without a command");

endmodule

bind mono_framebuffer_rect_raster_top mfr_checker u_mfr_checker (.*);
